>>> hdl/separable_binomial_blur_2d_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the separable binomial blur
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BINOMIAL_BLUR_2D_MACROS_SVH
`define SEPARABLE_BINOMIAL_BLUR_2D_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SBB_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define SBB_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`else
`define SBB_ASSERT_IMP(label, clk, rst, lhs, rhs, msg)
`define SBB_ASSERT_NXT(label, clk, rst, lhs, rhs, msg)
`endif
`endif

>>> hdl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// Separable binomial blur package
// Sizes, binomial coefficients, word types and rounding helpers.
// ----------------------------------------------------------------------------
package sbb_pkg;

   localparam int TAPS      = 9;
   localparam int HALF      = TAPS / 2;
   localparam int NBUF      = TAPS - 1;
   localparam int MAX_WIDTH = 2048;
   localparam int XW        = 11;   // column
   localparam int YW        = 12;   // output row
   localparam int RW        = 13;   // row counter
   localparam int WW        = 12;   // width register
   localparam int SLW       = 3;    // line slot
   localparam int KW        = 3;    // flush step count, 0..HALF
   localparam int VPW       = 24;   // coef * u8
   localparam int VSW       = 25;   // vertical partial sums
   localparam int HPW       = 32;   // coef * Q8.8
   localparam int HSW       = 33;   // horizontal partial sums
   localparam logic [WW-1:0] WIDTH_RESET = 12'd1024;

   // Pascal row 10, middle nine entries, scaled to Q0.16 (exact, shift by 6)
   localparam logic [15:0] COEF [TAPS] = '{
      16'd640, 16'd2880, 16'd7680, 16'd13440, 16'd16128,
      16'd13440, 16'd7680, 16'd2880, 16'd640
   };

   typedef logic [3:0][7:0]     pix_type;    // r,g,b,a
   typedef logic [3:0][15:0]    hpix_type;   // Q8.8 per channel
   typedef logic [3:0][VPW-1:0] vprod_type;
   typedef logic [3:0][HPW-1:0] hprod_type;

   // line buffer write word and vertical stage control
   typedef struct packed {
      logic           fire;
      logic           row0;
      logic [SLW-1:0] slot;
      logic [XW-1:0]  addr;
      pix_type        data;
   } lwr_type;

   function automatic logic [15:0] round_v(input logic [VSW-1:0] acc);
      logic [VSW-1:0] t;
      t = (acc + VSW'(128)) >> 8;
      return (t > VSW'(65535)) ? 16'hFFFF : t[15:0];
   endfunction

   function automatic logic [15:0] round_h(input logic [HSW-1:0] acc);
      logic [HSW:0] t;
      t = ({1'b0, acc} + (HSW+1)'(32768)) >> 16;
      return (t > (HSW+1)'(65535)) ? 16'hFFFF : t[15:0];
   endfunction

endpackage

>>> hdl/sbb_req_if.sv
// ----------------------------------------------------------------------------
// Pixel request channel
// Carries one RGBA8 pixel word with its kind and frame start flag.
// ----------------------------------------------------------------------------
interface sbb_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       frame_start;
   logic [7:0] pix_r;
   logic [7:0] pix_g;
   logic [7:0] pix_b;
   logic [7:0] pix_a;
   modport source (output valid, kind, frame_start, pix_r, pix_g, pix_b, pix_a,
                   input ready);
   modport sink   (input valid, kind, frame_start, pix_r, pix_g, pix_b, pix_a,
                   output ready);
endinterface

>>> hdl/sbb_rsp_if.sv
// ----------------------------------------------------------------------------
// Blurred pixel response channel
// Carries one Q8.8 RGBA word with its position and row end flag.
// ----------------------------------------------------------------------------
interface sbb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_r;
   logic [15:0] out_g;
   logic [15:0] out_b;
   logic [15:0] out_a;
   logic [10:0] out_x;
   logic [11:0] out_y;
   logic        row_end;
   modport source (output valid, out_r, out_g, out_b, out_a, out_x, out_y, row_end,
                   input ready);
   modport sink   (input valid, out_r, out_g, out_b, out_a, out_x, out_y, row_end,
                   output ready);
endinterface

>>> hdl/sbb_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the image width register write data.
// ----------------------------------------------------------------------------
interface sbb_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> hdl/sbb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/sbb_line_cell.sv
// ----------------------------------------------------------------------------
// Line buffer cell
// One image row of storage with write forwarding and its vertical tap product.
// ----------------------------------------------------------------------------
module sbb_line_cell (
   input  logic                   clock,
   input  logic [sbb_pkg::SLW-1:0] idx,
   input  logic                   rd_en,
   input  logic [sbb_pkg::XW-1:0] rd_addr,
   input  sbb_pkg::lwr_type       wr,
   output sbb_pkg::pix_type       e_raw,
   output sbb_pkg::vprod_type     prod
);
   import sbb_pkg::*;

   logic      wen;
   pix_type   ram_q;
   logic      fwd_hit_ff;
   pix_type   fwd_data_ff;
   pix_type   e_use;
   logic [SLW-1:0] ci;
   vprod_type prod_ff;
   vprod_type prod_in;

   // row 0 fills every buffer, later rows only the oldest slot
   assign wen = wr.fire && (wr.row0 || (wr.slot == idx));

   sbb_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_ram (
      .clock   (clock),
      .wr_en   (wen),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // a write in the read cycle to the same column wins over the old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= wen && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign e_raw = fwd_hit_ff ? fwd_data_ff : ram_q;
   assign e_use = wr.row0 ? wr.data : e_raw;
   assign ci    = idx - wr.slot;   // age of this row in the window

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         prod_in[ch] = VPW'(COEF[ci]) * VPW'(e_use[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.fire) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

>>> hdl/sbb_win_cell.sv
// ----------------------------------------------------------------------------
// Horizontal window cell
// One column of vertical results; shifts toward its neighbor each step.
// ----------------------------------------------------------------------------
module sbb_win_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               fill,
   input  logic               load,
   input  logic [15:0]        coef,
   input  sbb_pkg::hpix_type  v_in,
   input  sbb_pkg::hpix_type  nb,
   output sbb_pkg::hpix_type  ent,
   output sbb_pkg::hprod_type prod
);
   import sbb_pkg::*;

   hpix_type  ent_ff;
   hpix_type  ent_in;
   hprod_type prod_ff;
   hprod_type prod_in;

   // column 0 fills the window, otherwise take the neighbor's word
   always_comb begin
      ent_in = ent_ff;
      if (step) begin
         ent_in = fill ? v_in : nb;
      end
      for (int ch = 0; ch < 4; ch++) begin
         prod_in[ch] = HPW'(coef) * HPW'(ent_in[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign ent  = ent_ff;
   assign prod = prod_ff;
endmodule

>>> hdl/separable_binomial_blur_2d.sv
// Stages: an accepted pixel is registered in turn in S1, V1, V2, G, P, Q and R.
// Throughput: one pixel per cycle while the output is not stalled; the last pixel
// of a row holds the window chain and earlier stages for itself plus 4 flushed columns.
// The line buffers are 8 single-port-write RAMs read in the accept cycle.
// Reset (synchronous, high) clears counters, window and stage valids; width
// returns to 1024. Line buffer contents are undefined until written.
// ----------------------------------------------------------------------------
// Separable binomial blur, 9 taps
// Vertical pass over a row of line buffer cells, horizontal pass over a row
// of window cells, Q8.8 results with round half up and saturation.
// ----------------------------------------------------------------------------
`include "separable_binomial_blur_2d_macros.svh"

module separable_binomial_blur_2d (
   input  logic clock,
   input  logic reset,
   sbb_req_if.sink   req_bus,
   sbb_rsp_if.source rsp_bus,
   sbb_csr_if.sink   csr_bus
);
   import sbb_pkg::*;

   // configuration
   logic [WW-1:0] width_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_bus.valid) begin
         width_ff <= csr_bus.data;
      end
   end

   // stage handshakes
   logic s1_v_ff, v1_v_ff, v2_v_ff, g_v_ff, p_v_ff, q_v_ff, r_v_ff;
   logic s1_ready, v1_ready, v2_ready, g_in_ready, p_ready, q_ready, r_ready;
   logic req_fire, s1_fire, fire_h, emit, kdone;

   assign r_ready  = !r_v_ff || rsp_bus.ready;
   assign q_ready  = !q_v_ff || r_ready;
   assign p_ready  = !p_v_ff || q_ready;
   assign v2_ready = !v2_v_ff || g_in_ready;
   assign v1_ready = !v1_v_ff || v2_ready;
   assign s1_ready = !s1_v_ff || v1_ready;
   assign req_bus.ready = s1_ready;
   assign req_fire = req_bus.valid && s1_ready;
   assign s1_fire  = s1_v_ff && v1_ready;

   // accept stage: position counters
   logic [XW-1:0]  col_ff, col_in, x0;
   logic [RW-1:0]  row_ff, row_in, r0;
   logic [SLW-1:0] slot_ff, slot_in, sl0;
   logic [WW-1:0]  w_eff;
   logic           last0;

   always_comb begin
      x0  = req_bus.frame_start ? '0 : col_ff;
      r0  = req_bus.frame_start ? '0 : row_ff;
      sl0 = req_bus.frame_start ? '0 : slot_ff;
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (width_ff > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      last0   = {1'b0, x0} >= (w_eff - WW'(1));
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (req_fire) begin
         if (last0) begin
            col_in  = '0;
            row_in  = r0 + RW'(1);
            slot_in = (sl0 == SLW'(NBUF - 1)) ? '0 : sl0 + SLW'(1);
         end else begin
            col_in  = x0 + XW'(1);
            row_in  = r0;
            slot_in = sl0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // S1: line buffer read data
   logic [XW-1:0]  s1_x_ff, v1_x_ff, v2_x_ff;
   logic [SLW-1:0] s1_slot_ff;
   logic           s1_row0_ff, s1_kind_ff;
   pix_type        s1_pix_ff;
   logic           s1_last_ff, v1_last_ff, v2_last_ff;
   logic           s1_yok_ff, v1_yok_ff, v2_yok_ff;
   logic [YW-1:0]  s1_y_ff, v1_y_ff, v2_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff    <= x0;
         s1_slot_ff <= sl0;
         s1_row0_ff <= (r0 == '0);
         s1_kind_ff <= req_bus.kind;
         s1_pix_ff  <= {req_bus.pix_a, req_bus.pix_b, req_bus.pix_g, req_bus.pix_r};
         s1_last_ff <= last0;
         s1_yok_ff  <= (r0 >= RW'(HALF));
         s1_y_ff    <= YW'(r0 - RW'(HALF));
      end
   end

   // line buffer cells
   pix_type        e_raw [NBUF];
   vprod_type      lprod [NBUF];
   lwr_type        lwr;
   pix_type        pix;
   logic [SLW-1:0] newest;

   assign newest = s1_slot_ff - SLW'(1);
   assign pix    = s1_kind_ff ? e_raw[newest] : s1_pix_ff;

   always_comb begin
      lwr.fire = s1_fire;
      lwr.row0 = s1_row0_ff;
      lwr.slot = s1_slot_ff;
      lwr.addr = s1_x_ff;
      lwr.data = pix;
   end

   for (genvar j = 0; j < NBUF; j++) begin : g_line
      sbb_line_cell u_cell (
         .clock   (clock),
         .idx     (SLW'(j)),
         .rd_en   (req_fire),
         .rd_addr (x0),
         .wr      (lwr),
         .e_raw   (e_raw[j]),
         .prod    (lprod[j])
      );
   end

   // V1: products, newest tap is the incoming pixel
   vprod_type pprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_v_ff <= 1'b0;
      end else if (v1_ready) begin
         v1_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         for (int ch = 0; ch < 4; ch++) begin
            pprod_ff[ch] <= VPW'(COEF[TAPS-1]) * VPW'(pix[ch]);
         end
         v1_x_ff    <= s1_x_ff;
         v1_last_ff <= s1_last_ff;
         v1_yok_ff  <= s1_yok_ff;
         v1_y_ff    <= s1_y_ff;
      end
   end

   // V2: partial sums of the vertical taps
   logic [3:0][VSW-1:0] vlo_ff, vhi_ff, vlo_in, vhi_in;
   logic                v1_fire;

   assign v1_fire = v1_v_ff && v2_ready;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         vlo_in[ch] = '0;
         vhi_in[ch] = VSW'(pprod_ff[ch]);
         for (int j = 0; j < NBUF / 2; j++) begin
            vlo_in[ch] = vlo_in[ch] + VSW'(lprod[j][ch]);
         end
         for (int j = NBUF / 2; j < NBUF; j++) begin
            vhi_in[ch] = vhi_in[ch] + VSW'(lprod[j][ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_v_ff <= 1'b0;
      end else if (v2_ready) begin
         v2_v_ff <= v1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_fire) begin
         vlo_ff     <= vlo_in;
         vhi_ff     <= vhi_in;
         v2_x_ff    <= v1_x_ff;
         v2_last_ff <= v1_last_ff;
         v2_yok_ff  <= v1_yok_ff;
         v2_y_ff    <= v1_y_ff;
      end
   end

   // G: window step sequencer, flushes HALF extra columns at a row end
   hpix_type      g_word_ff, v_word;
   logic [XW-1:0] g_x_ff;
   logic          g_last_ff, g_yok_ff;
   logic [YW-1:0] g_y_ff;
   logic [KW-1:0] g_k_ff;
   logic          fill;
   logic [XW:0]   xk;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         v_word[ch] = round_v(vlo_ff[ch] + vhi_ff[ch]);
      end
   end

   assign xk         = {1'b0, g_x_ff} + (XW+1)'(g_k_ff);
   assign emit       = g_yok_ff && (xk >= (XW+1)'(HALF));
   assign kdone      = !g_last_ff || (g_k_ff == KW'(HALF));
   assign fire_h     = g_v_ff && (p_ready || !emit);
   assign g_in_ready = !g_v_ff || (fire_h && kdone);
   assign fill       = (g_k_ff == '0) && (g_x_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
         g_k_ff <= '0;
      end else if (g_in_ready) begin
         g_v_ff <= v2_v_ff;
         g_k_ff <= '0;
      end else if (fire_h) begin
         g_k_ff <= g_k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (v2_v_ff && g_in_ready) begin
         g_word_ff <= v_word;
         g_x_ff    <= v2_x_ff;
         g_last_ff <= v2_last_ff;
         g_yok_ff  <= v2_yok_ff;
         g_y_ff    <= v2_y_ff;
      end
   end

   // window cells
   hpix_type  ent [TAPS];
   hpix_type  nb  [TAPS];
   hprod_type hprod [TAPS];

   for (genvar j = 0; j < TAPS; j++) begin : g_win
      if (j == TAPS - 1) begin : g_edge
         assign nb[j] = g_word_ff;
      end else begin : g_mid
         assign nb[j] = ent[j+1];
      end
      sbb_win_cell u_cell (
         .clock (clock),
         .reset (reset),
         .step  (fire_h),
         .fill  (fill),
         .load  (fire_h && emit),
         .coef  (COEF[j]),
         .v_in  (g_word_ff),
         .nb    (nb[j]),
         .ent   (ent[j]),
         .prod  (hprod[j])
      );
   end

   // P: products held in the window cells
   logic [XW-1:0] p_x_ff, q_x_ff;
   logic [YW-1:0] p_y_ff, q_y_ff;
   logic          p_end_ff, q_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (p_ready) begin
         p_v_ff <= fire_h && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_h && emit) begin
         p_x_ff   <= XW'(xk - (XW+1)'(HALF));
         p_y_ff   <= g_y_ff;
         p_end_ff <= g_last_ff && kdone;
      end
   end

   // Q: partial sums of the horizontal taps
   logic [3:0][HSW-1:0] hlo_ff, hhi_ff, hlo_in, hhi_in;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         hlo_in[ch] = '0;
         hhi_in[ch] = '0;
         for (int j = 0; j < HALF; j++) begin
            hlo_in[ch] = hlo_in[ch] + HSW'(hprod[j][ch]);
         end
         for (int j = HALF; j < TAPS; j++) begin
            hhi_in[ch] = hhi_in[ch] + HSW'(hprod[j][ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff <= 1'b0;
      end else if (q_ready) begin
         q_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_v_ff && q_ready) begin
         hlo_ff   <= hlo_in;
         hhi_ff   <= hhi_in;
         q_x_ff   <= p_x_ff;
         q_y_ff   <= p_y_ff;
         q_end_ff <= p_end_ff;
      end
   end

   // R: output word register
   hpix_type      r_word_ff;
   logic [XW-1:0] r_x_ff;
   logic [YW-1:0] r_y_ff;
   logic          r_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (r_ready) begin
         r_v_ff <= q_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_v_ff && r_ready) begin
         for (int ch = 0; ch < 4; ch++) begin
            r_word_ff[ch] <= round_h(hlo_ff[ch] + hhi_ff[ch]);
         end
         r_x_ff   <= q_x_ff;
         r_y_ff   <= q_y_ff;
         r_end_ff <= q_end_ff;
      end
   end

   assign rsp_bus.valid   = r_v_ff;
   assign rsp_bus.out_r   = r_word_ff[0];
   assign rsp_bus.out_g   = r_word_ff[1];
   assign rsp_bus.out_b   = r_word_ff[2];
   assign rsp_bus.out_a   = r_word_ff[3];
   assign rsp_bus.out_x   = r_x_ff;
   assign rsp_bus.out_y   = r_y_ff;
   assign rsp_bus.row_end = r_end_ff;

   // checks
   `SBB_ASSERT_IMP(a_flush_only_last, clock, reset, g_v_ff && (g_k_ff != '0), g_last_ff, "stray flush")
   `SBB_ASSERT_IMP(a_flush_bound, clock, reset, g_v_ff, g_k_ff <= KW'(HALF), "flush overrun")
   `SBB_ASSERT_NXT(a_accept_lands, clock, reset, req_fire, s1_v_ff, "accepted word lost")
endmodule
